### design/utf8_to_utf16_transcoder_assert.svh
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_assert
// Assertion macros used by the transcoder top level.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define U2U_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("transcoder assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define U2U_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("transcoder assertion failed");

`endif

### design/u2u_pkg.sv
// ----------------------------------------------------------------------------
// u2u_pkg
// Types and constants shared by the UTF-8 to UTF-16 transcoder modules.
// ----------------------------------------------------------------------------
package u2u_pkg;

   localparam logic [15:0] REPLACEMENT_UNIT = 16'hFFFD;
   localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;
   localparam logic [15:0] HIGH_SURROGATE_BASE = 16'hD800;
   localparam logic [15:0] LOW_SURROGATE_BASE = 16'hDC00;

   // Number of units held in one queue entry
   localparam logic [1:0] UNITS_NONE = 2'd0;
   localparam logic [1:0] UNITS_ONE = 2'd1;
   localparam logic [1:0] UNITS_TWO = 2'd2;

   // All units caused by one accepted byte
   typedef struct packed {
      logic [1:0]  unit_count;
      logic [15:0] unit0;
      logic [15:0] unit1;
      logic        end_of_text;
   } u2u_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } u2u_queue_status_type;

endpackage

### design/u2u_front.sv
// ----------------------------------------------------------------------------
// u2u_front
// Accepts UTF-8 bytes, tracks the open sequence and builds queue entries.
// ----------------------------------------------------------------------------
module u2u_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_end_of_text,
   input  u2u_pkg::u2u_queue_status_type q_status,
   output logic                          push,
   output u2u_pkg::u2u_entry_type        push_entry
);

   logic [20:0] partial_ff, partial_in;
   logic [1:0]  expected_ff, expected_in;

   logic          accept;
   logic          is_cont;
   logic          lead_open;
   logic [1:0]    lead_expected;
   logic [20:0]   lead_bits;
   logic          lead_unit_valid;
   logic [15:0]   lead_unit;
   logic [20:0]   grown;
   logic [1:0]    expected_dec;
   logic [20:0]   offset;
   u2u_pkg::u2u_entry_type entry;

   assign req_ready = !q_status.full;
   assign accept = req_valid && req_ready;
   assign is_cont = (req_data_byte[7:6] == 2'b10);
   assign grown = {partial_ff[14:0], req_data_byte[5:0]};
   assign expected_dec = expected_ff - 2'd1;
   assign offset = grown - u2u_pkg::SUPPLEMENTARY_BASE;

   // Lead byte decode
   always_comb begin
      lead_open = 1'b0;
      lead_expected = 2'd0;
      lead_bits = '0;
      lead_unit_valid = 1'b0;
      lead_unit = u2u_pkg::REPLACEMENT_UNIT;
      if (!req_data_byte[7]) begin
         lead_unit_valid = 1'b1;
         lead_unit = {8'h00, req_data_byte};
      end else if (req_data_byte[7:5] == 3'b110) begin
         lead_open = 1'b1;
         lead_expected = 2'd1;
         lead_bits = {16'h0000, req_data_byte[4:0]};
      end else if (req_data_byte[7:4] == 4'b1110) begin
         lead_open = 1'b1;
         lead_expected = 2'd2;
         lead_bits = {17'h00000, req_data_byte[3:0]};
      end else if (req_data_byte[7:3] == 5'b11110) begin
         lead_open = 1'b1;
         lead_expected = 2'd3;
         lead_bits = {18'h00000, req_data_byte[2:0]};
      end else begin
         lead_unit_valid = 1'b1;
      end
      // flush a sequence opened on the last byte as its partial value
      if (lead_open && req_end_of_text) begin
         lead_unit_valid = 1'b1;
         lead_unit = lead_bits[15:0];
      end
   end

   // Entry and next state
   always_comb begin
      entry.unit_count = u2u_pkg::UNITS_NONE;
      entry.unit0 = lead_unit;
      entry.unit1 = lead_unit;
      entry.end_of_text = req_end_of_text;
      partial_in = partial_ff;
      expected_in = expected_ff;
      if ((expected_ff != 2'd0) && is_cont) begin
         if ((expected_dec == 2'd0) || req_end_of_text) begin
            partial_in = '0;
            expected_in = 2'd0;
            if (grown[20:16] != 5'd0) begin
               entry.unit_count = u2u_pkg::UNITS_TWO;
               entry.unit0 = u2u_pkg::HIGH_SURROGATE_BASE + {5'd0, offset[20:10]};
               entry.unit1 = u2u_pkg::LOW_SURROGATE_BASE + {6'd0, offset[9:0]};
            end else begin
               entry.unit_count = u2u_pkg::UNITS_ONE;
               entry.unit0 = grown[15:0];
            end
         end else begin
            partial_in = grown;
            expected_in = expected_dec;
         end
      end else begin
         // broken sequence: replace, then decode this byte again as a lead; with no open sequence, decode it as a lead
         if (expected_ff != 2'd0) begin
            entry.unit0 = u2u_pkg::REPLACEMENT_UNIT;
            entry.unit_count = lead_unit_valid ? u2u_pkg::UNITS_TWO : u2u_pkg::UNITS_ONE;
         end else begin
            entry.unit_count = lead_unit_valid ? u2u_pkg::UNITS_ONE : u2u_pkg::UNITS_NONE;
         end
         if (lead_open && !req_end_of_text) begin
            partial_in = lead_bits;
            expected_in = lead_expected;
         end else begin
            partial_in = '0;
            expected_in = 2'd0;
         end
      end
   end

   assign push = accept && (entry.unit_count != u2u_pkg::UNITS_NONE);
   assign push_entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         expected_ff <= 2'd0;
      end else if (accept) begin
         partial_ff <= partial_in;
         expected_ff <= expected_in;
      end
   end

endmodule

### design/u2u_queue.sv
// ----------------------------------------------------------------------------
// u2u_queue
// Short first-in first-out queue of entries between front and back.
// ----------------------------------------------------------------------------
module u2u_queue #(
   parameter int DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  u2u_pkg::u2u_entry_type        push_entry,
   input  logic                          pop,
   output u2u_pkg::u2u_entry_type        head_entry,
   output u2u_pkg::u2u_queue_status_type q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   u2u_pkg::u2u_entry_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign q_status.full = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push = push && !q_status.full;
   assign do_pop = pop && !q_status.empty;
   assign head_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

### design/u2u_back.sv
// ----------------------------------------------------------------------------
// u2u_back
// Drains queue entries one code unit per cycle, while rsp_ready allows, into the output register.
// ----------------------------------------------------------------------------
module u2u_back (
   input  logic                          clock,
   input  logic                          reset,
   input  u2u_pkg::u2u_entry_type        head_entry,
   input  u2u_pkg::u2u_queue_status_type q_status,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [15:0]                   rsp_code_unit,
   output logic                          rsp_last_of_run,
   output logic                          rsp_text_done
);

   logic        valid_ff, valid_in;
   logic        second_ff, second_in;
   logic [15:0] unit_ff;
   logic        last_ff;
   logic        done_ff;
   logic        load;
   logic        head_last;

   // Load when the queue has an entry and the output register is free or being emptied this cycle
   assign load = !q_status.empty && (!valid_ff || rsp_ready);
   assign head_last = second_ff || (head_entry.unit_count == u2u_pkg::UNITS_ONE);
   assign pop = load && head_last;

   always_comb begin
      valid_in = valid_ff;
      second_in = second_ff;
      if (load) begin
         valid_in = 1'b1;
         second_in = !head_last;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         unit_ff <= second_ff ? head_entry.unit1 : head_entry.unit0;
         last_ff <= head_last;
         done_ff <= head_last && head_entry.end_of_text;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_code_unit = unit_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_text_done = done_ff;

endmodule

### design/utf8_to_utf16_transcoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Streaming UTF-8 to UTF-16 transcoder with a decoupled front and back.
// ----------------------------------------------------------------------------
// Takes one UTF-8 byte per word on the req_ channel, with req_end_of_text set
// on the last byte of a text, and gives UTF-16 code units on the rsp_ channel.
// A byte is taken every cycle while the entry queue has room; a byte that
// yields a surrogate pair, or a replacement followed by a re-decoded lead,
// gives two units on the output, and the queue of QUEUE_DEPTH entries
// soaks up those extra units. A lead byte that opens a sequence yields no
// word. The first unit of a byte goes through the entry queue and then the
// output register. rsp_last_of_run marks the final unit of each byte,
// rsp_text_done the final unit of a text; after it the decoder is back in its
// reset state. Invalid leads and broken sequences give U+FFFD; a sequence cut
// short by the end of the text is flushed as the bits gathered so far.
// Overlong forms and surrogate code points pass through unchecked.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_transcoder_assert.svh"

module utf8_to_utf16_transcoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_last_of_run,
   output logic        rsp_text_done
);

   u2u_pkg::u2u_queue_status_type q_status;
   u2u_pkg::u2u_entry_type        push_entry;
   u2u_pkg::u2u_entry_type        head_entry;
   logic                          push;
   logic                          pop;

   // Front: decode bytes, hold the open sequence, build entries
   u2u_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_end_of_text (req_end_of_text),
      .q_status        (q_status),
      .push            (push),
      .push_entry      (push_entry)
   );

   // Queue: decouple the byte side from the unit side
   u2u_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   // Back: emit one unit per cycle, while rsp_ready allows, from the head entry
   u2u_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_entry      (head_entry),
      .q_status        (q_status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_unit   (rsp_code_unit),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_text_done   (rsp_text_done)
   );

   // Hold off bytes while the queue is full
   `U2U_ASSERT_NOW(a_full_blocks_req, clock, reset, q_status.full, !req_ready)
   // Never queue an entry that carries no unit
   `U2U_ASSERT_NOW(a_no_empty_entry, clock, reset, push, push_entry.unit_count != u2u_pkg::UNITS_NONE)
   // End of text only on the final unit of a byte
   `U2U_ASSERT_NOW(a_done_is_last, clock, reset, rsp_valid && rsp_text_done, rsp_last_of_run)
   // Second unit of a byte follows straight after the first
   `U2U_ASSERT_NEXT(a_pair_back_to_back, clock, reset,
      rsp_valid && rsp_ready && !rsp_last_of_run, rsp_valid)

endmodule
